// ===== src/fbpa_pkg.sv =====
`default_nettype none

package fbpa_pkg;

   // Field widths of the item and result channels.
   localparam int FUNC_W      = 3;
   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int STATUS_W    = 3;
   localparam int EVENT_W     = 32;
   localparam int CSR_INDEX_W = 2;

   // Operation codes carried by req_func.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE        = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXPAND      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR       = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESET_STATS = 3'd4;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK            = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_OUT_OF_BLOCKS = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_INVALID_FREE  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_COUNT    = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEAR_SKIPPED = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROW_STEP     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_LIMIT   = 2'd2;

   // Values used when a size register holds zero, and register reset values.
   localparam logic [COUNT_W-1:0] DEFAULT_INITIAL = 9'd16;
   localparam logic [COUNT_W-1:0] DEFAULT_STEP    = 9'd8;
   localparam logic [COUNT_W-1:0] RESET_LIMIT     = 9'd0;

   // Controller states.
   typedef enum logic [4:0] {
      ST_SWEEP = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_EXEC  = 5'b00100,
      ST_GROW  = 5'b01000,
      ST_DONE  = 5'b10000
   } fsm_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic sweep_step;
      logic grow_start;
      logic grow_step;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sweep_last;
      logic need_grow;
      logic grow_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/fixed_block_pool_allocator_unit.sv =====
`default_nettype none

// Channel    Direction  Handshake               Payload
// req_       in         req_valid / req_stall   func, block_index, grow_count
// rsp_       out        rsp_valid / rsp_stall   status, granted_index, counts, events
// csr_       in         csr_write_enable        csr_index, csr_write_data
//
// Alloc hit, free, clear skipped, reset stats and failed growth go through
// accept with the free list and allocation map read, then commit.
// A growth of k blocks adds one push per index through the single write
// port of the free list (an alloc miss pushes the effective grow step - 1).
// After reset a sweep clears the allocation map and lays down the initial
// blocks; no item is taken until it ends.
// A result waits in the output register; a stalled result only delays commit.

module fixed_block_pool_allocator_unit
   import fbpa_pkg::*;
#(
   parameter int POOL_CAPACITY = 256,
   parameter int COUNTER_BITS  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic [INDEX_W-1:0]     req_block_index,
   input  wire logic [COUNT_W-1:0]     req_grow_count,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [INDEX_W-1:0]          rsp_granted_index,
   output logic [COUNT_W-1:0]          rsp_free_now,
   output logic [COUNT_W-1:0]          rsp_in_use_now,
   output logic [COUNT_W-1:0]          rsp_pool_size,
   output logic [EVENT_W-1:0]          rsp_hits,
   output logic [EVENT_W-1:0]          rsp_misses,
   output logic [EVENT_W-1:0]          rsp_alloc_events,
   output logic [EVENT_W-1:0]          rsp_free_events,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_write_data
);

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   // Sequencer.
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Free list, allocation map, counters and result register.
   fbpa_datapath #(
      .POOL_CAPACITY (POOL_CAPACITY),
      .COUNTER_BITS  (COUNTER_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_func          (req_func),
      .req_block_index   (req_block_index),
      .req_grow_count    (req_grow_count),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_granted_index (rsp_granted_index),
      .rsp_free_now      (rsp_free_now),
      .rsp_in_use_now    (rsp_in_use_now),
      .rsp_pool_size     (rsp_pool_size),
      .rsp_hits          (rsp_hits),
      .rsp_misses        (rsp_misses),
      .rsp_alloc_events  (rsp_alloc_events),
      .rsp_free_events   (rsp_free_events)
   );

   // A result is never written over one that is still held.
   assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid && rsp_stall))
      else $error("result register overwritten while stalled");

   // Only one item is in the block at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item taken while another is in progress");

   // Every block is either on the free list or allocated.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (COUNT_W'(rsp_free_now + rsp_in_use_now) == rsp_pool_size))
      else $error("free and allocated counts do not add up to the pool size");

endmodule

`default_nettype wire

// ===== src/fbpa_ctrl.sv =====
`default_nettype none

module fbpa_ctrl
   import fbpa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire dp_status_type stat,
   output ctrl_cmd_type       cmd
);

   fsm_state_type state_ff;
   fsm_state_type state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (stat.need_grow) begin
               cmd.grow_start = 1'b1;
               state_in       = ST_GROW;
            end else if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_GROW: begin
            cmd.grow_step = 1'b1;
            if (stat.grow_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Items are taken only while the controller waits for work.
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/fbpa_datapath.sv =====
`default_nettype none

module fbpa_datapath
   import fbpa_pkg::*;
#(
   parameter int POOL_CAPACITY = 256,
   parameter int COUNTER_BITS  = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ctrl_cmd_type           cmd,
   output dp_status_type               stat,
   input  wire logic [FUNC_W-1:0]      req_func,
   input  wire logic [INDEX_W-1:0]     req_block_index,
   input  wire logic [COUNT_W-1:0]     req_grow_count,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COUNT_W-1:0]     csr_write_data,
   input  wire logic                   rsp_stall,
   output logic                        rsp_valid,
   output logic [STATUS_W-1:0]         rsp_status,
   output logic [INDEX_W-1:0]          rsp_granted_index,
   output logic [COUNT_W-1:0]          rsp_free_now,
   output logic [COUNT_W-1:0]          rsp_in_use_now,
   output logic [COUNT_W-1:0]          rsp_pool_size,
   output logic [EVENT_W-1:0]          rsp_hits,
   output logic [EVENT_W-1:0]          rsp_misses,
   output logic [EVENT_W-1:0]          rsp_alloc_events,
   output logic [EVENT_W-1:0]          rsp_free_events
);

   localparam int IDX_W       = $clog2(POOL_CAPACITY);
   localparam int CNT_W       = $clog2(POOL_CAPACITY + 1);
   localparam int SUM_W       = ((CNT_W > COUNT_W) ? CNT_W : COUNT_W) + 1;
   localparam int INIT_BLOCKS = (POOL_CAPACITY < int'(DEFAULT_INITIAL)) ?
                                POOL_CAPACITY : int'(DEFAULT_INITIAL);
   localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(POOL_CAPACITY);
   localparam logic [CNT_W-1:0] INIT_C   = CNT_W'(INIT_BLOCKS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POOL_CAPACITY - 1);

   // A growth of k blocks must be nonzero and stay within the capacity and the block limit.
   function automatic logic grow_ok(input logic [CNT_W-1:0]   total,
                                    input logic [COUNT_W-1:0] k,
                                    input logic [COUNT_W-1:0] limit);
      logic [SUM_W-1:0] sum;
      logic             fits;
      sum  = SUM_W'(total) + SUM_W'(k);
      fits = (k != '0) && (SUM_W'(k) <= CAP_S) && (sum <= CAP_S);
      return fits && ((limit == '0) || (sum <= SUM_W'(limit)));
   endfunction

   // Free list and allocation map.
   logic [IDX_W-1:0] stack_mem [POOL_CAPACITY];
   logic             live_mem  [POOL_CAPACITY];

   logic             stack_we;
   logic [IDX_W-1:0] stack_waddr;
   logic [IDX_W-1:0] stack_wdata;
   logic [IDX_W-1:0] stack_raddr;
   logic [IDX_W-1:0] stack_rd_ff;
   logic             live_we;
   logic [IDX_W-1:0] live_waddr;
   logic             live_wdata;
   logic [IDX_W-1:0] live_raddr;
   logic             live_rd_ff;

   // Captured item.
   logic [FUNC_W-1:0]  func_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [COUNT_W-1:0] cnt_ff;
   logic               empty_ff;

   // Pool bookkeeping.
   logic [CNT_W-1:0] depth_ff,  depth_in;
   logic [CNT_W-1:0] total_ff,  total_in;
   logic [CNT_W-1:0] in_use_ff, in_use_in;

   logic [COUNTER_BITS-1:0] hits_ff,   hits_in;
   logic [COUNTER_BITS-1:0] misses_ff, misses_in;
   logic [COUNTER_BITS-1:0] allocs_ff, allocs_in;
   logic [COUNTER_BITS-1:0] frees_ff,  frees_in;

   logic [COUNT_W-1:0] initial_ff, initial_in;
   logic [COUNT_W-1:0] step_ff,    step_in;
   logic [COUNT_W-1:0] limit_ff,   limit_in;

   // Sweep after reset and growth sequencing.
   logic [IDX_W-1:0]   sweep_ff, sweep_in;
   logic [COUNT_W-1:0] gctr_ff,  gctr_in;
   logic [COUNT_W-1:0] glen_ff,  glen_in;
   logic [CNT_W-1:0]   gbase_ff, gbase_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_granted_ff;
   logic [COUNT_W-1:0]  rsp_free_ff;
   logic [COUNT_W-1:0]  rsp_in_use_ff;
   logic [COUNT_W-1:0]  rsp_pool_ff;
   logic [EVENT_W-1:0]  rsp_hits_ff;
   logic [EVENT_W-1:0]  rsp_misses_ff;
   logic [EVENT_W-1:0]  rsp_allocs_ff;
   logic [EVENT_W-1:0]  rsp_frees_ff;

   logic [COUNT_W-1:0]  eff_step;
   logic [COUNT_W-1:0]  init_raw;
   logic [COUNT_W-1:0]  eff_init;
   logic                ok_step;
   logic                ok_cnt;
   logic                ok_init;
   logic                free_ok;
   logic [COUNT_W-1:0]  plan_len;
   logic [CNT_W-1:0]    plan_base;
   logic [SUM_W-1:0]    step_sum;
   logic [STATUS_W-1:0] status_code;
   logic [IDX_W-1:0]    grant;

   // Effective sizes and growth checks for the current item.
   always_comb begin
      eff_step = (step_ff == '0) ? DEFAULT_STEP : step_ff;
      init_raw = (initial_ff == '0) ? DEFAULT_INITIAL : initial_ff;
      eff_init = (SUM_W'(init_raw) > CAP_S) ? COUNT_W'(POOL_CAPACITY) : init_raw;
      ok_step  = grow_ok(total_ff, eff_step, limit_ff);
      ok_cnt   = grow_ok(total_ff, cnt_ff, limit_ff);
      ok_init  = grow_ok('0, eff_init, limit_ff);
      step_sum = SUM_W'(total_ff) + SUM_W'(eff_step);
      free_ok  = (SUM_W'(idx_ff) < SUM_W'(total_ff)) && (SUM_W'(idx_ff) < CAP_S) &&
                 live_rd_ff && (SUM_W'(depth_ff) < CAP_S);
   end

   // Push plan: how many indices to push and the first index value.
   always_comb begin
      plan_len       = '0;
      plan_base      = total_ff;
      stat.need_grow = 1'b0;
      case (func_ff)
         FUNC_ALLOC: begin
            plan_len       = eff_step - COUNT_W'(1);
            stat.need_grow = empty_ff && ok_step && (eff_step != COUNT_W'(1));
         end
         FUNC_EXPAND: begin
            plan_len       = cnt_ff;
            stat.need_grow = ok_cnt;
         end
         FUNC_CLEAR: begin
            plan_len       = eff_init;
            plan_base      = '0;
            stat.need_grow = (in_use_ff == '0) && ok_init;
         end
         default: begin
            stat.need_grow = 1'b0;
         end
      endcase
   end

   assign stat.sweep_last = (sweep_ff == LAST_IDX);
   assign stat.grow_last  = (gctr_ff == glen_ff - COUNT_W'(1));
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign stack_raddr = depth_ff[IDX_W-1:0] - IDX_W'(1);
   assign live_raddr  = IDX_W'(req_block_index);

   // Next values of the pool state, the counters and the memory writes.
   always_comb begin
      depth_in     = depth_ff;
      total_in     = total_ff;
      in_use_in    = in_use_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      allocs_in    = allocs_ff;
      frees_in     = frees_ff;
      sweep_in     = sweep_ff;
      gctr_in      = gctr_ff;
      glen_in      = glen_ff;
      gbase_in     = gbase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_code  = STATUS_OK;
      grant        = '0;
      stack_we     = 1'b0;
      stack_waddr  = depth_ff[IDX_W-1:0];
      stack_wdata  = IDX_W'(idx_ff);
      live_we      = 1'b0;
      live_waddr   = IDX_W'(idx_ff);
      live_wdata   = 1'b0;

      // The sweep after reset clears the map and lays down the initial blocks.
      if (cmd.sweep_step) begin
         live_we     = 1'b1;
         live_waddr  = sweep_ff;
         stack_we    = (CNT_W'(sweep_ff) < INIT_C);
         stack_waddr = sweep_ff;
         stack_wdata = sweep_ff;
         sweep_in    = sweep_ff + IDX_W'(1);
      end

      // Clear rebuilds from an empty list.
      if (cmd.grow_start) begin
         gctr_in  = '0;
         glen_in  = plan_len;
         gbase_in = plan_base;
         if (func_ff == FUNC_CLEAR) begin
            depth_in = '0;
         end
      end

      // One new index pushed per cycle.
      if (cmd.grow_step) begin
         stack_we    = 1'b1;
         stack_wdata = IDX_W'(gbase_ff + CNT_W'(gctr_ff));
         depth_in    = depth_ff + CNT_W'(1);
         gctr_in     = gctr_ff + COUNT_W'(1);
      end

      // Commit the item and load the result.
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         case (func_ff)
            FUNC_ALLOC: begin
               if (!empty_ff) begin
                  hits_in    = hits_ff + COUNTER_BITS'(1);
                  grant      = stack_rd_ff;
                  live_we    = 1'b1;
                  live_waddr = grant;
                  live_wdata = 1'b1;
                  depth_in   = depth_ff - CNT_W'(1);
                  in_use_in  = in_use_ff + CNT_W'(1);
                  allocs_in  = allocs_ff + COUNTER_BITS'(1);
               end else begin
                  misses_in = misses_ff + COUNTER_BITS'(1);
                  if (!ok_step) begin
                     status_code = STATUS_OUT_OF_BLOCKS;
                  end else begin
                     total_in   = CNT_W'(step_sum);
                     grant      = IDX_W'(step_sum - SUM_W'(1));
                     live_we    = 1'b1;
                     live_waddr = grant;
                     live_wdata = 1'b1;
                     in_use_in  = in_use_ff + CNT_W'(1);
                     allocs_in  = allocs_ff + COUNTER_BITS'(1);
                  end
               end
            end
            FUNC_FREE: begin
               if (!free_ok) begin
                  status_code = STATUS_INVALID_FREE;
               end else begin
                  live_we   = 1'b1;
                  stack_we  = 1'b1;
                  depth_in  = depth_ff + CNT_W'(1);
                  in_use_in = (in_use_ff != '0) ? in_use_ff - CNT_W'(1) : in_use_ff;
                  frees_in  = frees_ff + COUNTER_BITS'(1);
               end
            end
            FUNC_EXPAND: begin
               if (cnt_ff == '0) begin
                  status_code = STATUS_ZERO_COUNT;
               end else if (!ok_cnt) begin
                  status_code = STATUS_OUT_OF_BLOCKS;
               end else begin
                  total_in = CNT_W'(SUM_W'(total_ff) + SUM_W'(cnt_ff));
               end
            end
            FUNC_CLEAR: begin
               // A clear goes ahead only when nothing is allocated, so the map is already clear.
               if (in_use_ff != '0) begin
                  status_code = STATUS_CLEAR_SKIPPED;
               end else begin
                  total_in  = ok_init ? CNT_W'(eff_init) : '0;
                  depth_in  = ok_init ? depth_ff : '0;
                  in_use_in = '0;
               end
            end
            FUNC_RESET_STATS: begin
               hits_in   = '0;
               misses_in = '0;
               allocs_in = '0;
               frees_in  = '0;
            end
            default: begin
               status_code = STATUS_OK;
            end
         endcase
      end
   end

   // Configuration writes.
   always_comb begin
      initial_in = initial_ff;
      step_in    = step_ff;
      limit_in   = limit_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_INITIAL_COUNT: initial_in = csr_write_data;
            CSR_GROW_STEP:     step_in    = csr_write_data;
            CSR_BLOCK_LIMIT:   limit_in   = csr_write_data;
            default:           initial_in = initial_ff;
         endcase
      end
   end

   // Memories with registered read data.
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_waddr] <= stack_wdata;
      end
      if (cmd.accept) begin
         stack_rd_ff <= stack_mem[stack_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      if (cmd.accept) begin
         live_rd_ff <= live_mem[live_raddr];
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= INIT_C;
         total_ff     <= INIT_C;
         in_use_ff    <= '0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         allocs_ff    <= '0;
         frees_ff     <= '0;
         initial_ff   <= DEFAULT_INITIAL;
         step_ff      <= DEFAULT_STEP;
         limit_ff     <= RESET_LIMIT;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff     <= depth_in;
         total_ff     <= total_in;
         in_use_ff    <= in_use_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         allocs_ff    <= allocs_in;
         frees_ff     <= frees_in;
         initial_ff   <= initial_in;
         step_ff      <= step_in;
         limit_ff     <= limit_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item capture, growth sequencing and result payload.
   always_ff @(posedge clock) begin
      gctr_ff  <= gctr_in;
      glen_ff  <= glen_in;
      gbase_ff <= gbase_in;
      if (cmd.accept) begin
         func_ff  <= req_func;
         idx_ff   <= req_block_index;
         cnt_ff   <= req_grow_count;
         empty_ff <= (depth_ff == '0);
      end
      if (cmd.finish) begin
         rsp_status_ff  <= status_code;
         rsp_granted_ff <= INDEX_W'(grant);
         rsp_free_ff    <= COUNT_W'(depth_in);
         rsp_in_use_ff  <= COUNT_W'(in_use_in);
         rsp_pool_ff    <= COUNT_W'(total_in);
         rsp_hits_ff    <= EVENT_W'(hits_in);
         rsp_misses_ff  <= EVENT_W'(misses_in);
         rsp_allocs_ff  <= EVENT_W'(allocs_in);
         rsp_frees_ff   <= EVENT_W'(frees_in);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_index = rsp_granted_ff;
   assign rsp_free_now      = rsp_free_ff;
   assign rsp_in_use_now    = rsp_in_use_ff;
   assign rsp_pool_size     = rsp_pool_ff;
   assign rsp_hits          = rsp_hits_ff;
   assign rsp_misses        = rsp_misses_ff;
   assign rsp_alloc_events  = rsp_allocs_ff;
   assign rsp_free_events   = rsp_frees_ff;

endmodule

`default_nettype wire
